>>> hdl/assert_macros.svh
// Assertion macros shared by the row marker history search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define RMHS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked at every clock edge, reset included.
`define RMHS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMHS_ASSERT(label, clk, rst, prop, msg)
`define RMHS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> hdl/rmhs_pkg.sv
// Package with types and constants of the row marker history search.
package rmhs_pkg;

   localparam int MAX_MARKERS_DEFAULT = 64;
   localparam int ROW_BITS_DEFAULT    = 32;
   localparam int LIMIT_BITS          = 7;
   localparam int CMD_BITS            = 2;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd64;

   localparam logic [CMD_BITS-1:0] CMD_MARK = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_UP   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DOWN = 2'd2;

   // What every cell of the chain does in a cycle.
   typedef enum logic [1:0] {
      OP_HOLD   = 2'b00,
      OP_PUSH   = 2'b01,
      OP_ROTATE = 2'b10
   } chain_op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

>>> hdl/rmhs_cell.sv
// One cell of the marker chain: holds one row and takes a neighbour's value.
module rmhs_cell #(
   parameter int ROW_BITS = rmhs_pkg::ROW_BITS_DEFAULT
) (
   input  logic                  clock,
   input  rmhs_pkg::chain_op_type op,
   input  logic [ROW_BITS-1:0]   from_prev,
   input  logic [ROW_BITS-1:0]   from_next,
   output logic [ROW_BITS-1:0]   value
);

   logic [ROW_BITS-1:0] value_ff;
   logic [ROW_BITS-1:0] value_in;

   always_comb begin
      unique case (op)
         rmhs_pkg::OP_PUSH:   value_in = from_prev;
         rmhs_pkg::OP_ROTATE: value_in = from_next;
         default:             value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> hdl/rmhs_chain.sv
// Row of marker cells, newest in cell 0; pushes shift down, rotation shifts up.
module rmhs_chain #(
   parameter int MAX_MARKERS = rmhs_pkg::MAX_MARKERS_DEFAULT,
   parameter int ROW_BITS    = rmhs_pkg::ROW_BITS_DEFAULT
) (
   input  logic                  clock,
   input  rmhs_pkg::chain_op_type op,
   input  logic [ROW_BITS-1:0]   push_row,
   output logic [ROW_BITS-1:0]   head_row
);

   logic [ROW_BITS-1:0] cell_value [MAX_MARKERS];

   for (genvar i = 0; i < MAX_MARKERS; i++) begin : g_cell
      logic [ROW_BITS-1:0] prev_value;
      logic [ROW_BITS-1:0] next_value;

      if (i == 0) begin : g_first
         assign prev_value = push_row;
      end else begin : g_inner_prev
         assign prev_value = cell_value[i-1];
      end

      // The last cell wraps round to the head, so a full rotation restores the order.
      if (i == MAX_MARKERS - 1) begin : g_last
         assign next_value = cell_value[0];
      end else begin : g_inner_next
         assign next_value = cell_value[i+1];
      end

      rmhs_cell #(
         .ROW_BITS (ROW_BITS)
      ) u_cell (
         .clock     (clock),
         .op        (op),
         .from_prev (prev_value),
         .from_next (next_value),
         .value     (cell_value[i])
      );
   end

   assign head_row = cell_value[0];

endmodule

>>> hdl/row_marker_history_search.sv
// Top level of the row marker history search.
//
// Items enter on the req_ stream: req_tuser carries the command (mark, search
// upward, search downward) and req_tdata the row. Every item gives exactly one
// item on the rsp_ stream: rsp_tuser says whether a marker was found and
// rsp_tdata holds its row, or 0 when none.
// A mark item's result is in the result register in the cycle after acceptance,
// and the next item can be taken once that result has moved to the output
// register. A search rotates the whole chain of MAX_MARKERS cells once past a
// single comparator at the head, and its result is in the result register
// when the walk ends. The chain is back in its original order when the walk
// ends. One item is worked on at a time.
// csr_we writes the marker limit from csr_wdata; write it only while idle.
// Reset empties the history and sets the limit to 64; cell contents are not
// cleared. When the receiver stalls, the finished result waits in the output
// register while the next item is taken and worked on; that item's result then
// waits internally until the output register is free.
module row_marker_history_search #(
   parameter int MAX_MARKERS = rmhs_pkg::MAX_MARKERS_DEFAULT,
   parameter int ROW_BITS    = rmhs_pkg::ROW_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: row, zero padded to whole bytes
   input  logic [((ROW_BITS+7)/8)*8-1:0]  req_tdata,
   // tuser: cmd
   input  logic [rmhs_pkg::CMD_BITS-1:0]  req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: target_row, zero padded to whole bytes
   output logic [((ROW_BITS+7)/8)*8-1:0]  rsp_tdata,
   // tuser: jump_valid
   output logic                           rsp_tuser,
   input  logic                           csr_we,
   input  logic [rmhs_pkg::LIMIT_BITS-1:0] csr_wdata
);

`include "assert_macros.svh"

   localparam int DATA_W = ((ROW_BITS + 7) / 8) * 8;
   localparam int IDX_W  = $clog2(MAX_MARKERS);
   localparam int CNT_W  = $clog2(MAX_MARKERS + 1);
   localparam int CMP_W  = (CNT_W > rmhs_pkg::LIMIT_BITS) ? CNT_W : rmhs_pkg::LIMIT_BITS;
   localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_MARKERS);
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_MARKERS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_MARKERS - 1);

   rmhs_pkg::state_type state_ff, state_in;
   logic [rmhs_pkg::LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   logic [rmhs_pkg::CMD_BITS-1:0] cmd_ff, cmd_in;
   logic [ROW_BITS-1:0] bound_ff, bound_in;
   logic [ROW_BITS-1:0] prev_ff, prev_in;
   logic                hit_ff, hit_in;
   logic                res_jv_ff, res_jv_in;
   logic [ROW_BITS-1:0] res_row_ff, res_row_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_jv_ff, out_jv_in;
   logic [ROW_BITS-1:0] out_row_ff, out_row_in;

   rmhs_pkg::chain_op_type chain_op;
   logic [ROW_BITS-1:0] req_row;
   logic [ROW_BITS-1:0] head_row;
   logic [ROW_BITS-1:0] head_value;
   logic                accept;
   logic                out_free;
   logic                in_history;
   logic                at_or_below;
   logic [CMP_W-1:0]    limit_cmp;
   logic [CMP_W-1:0]    eff_limit;
   logic [CMP_W-1:0]    count_next_cmp;

   rmhs_chain #(
      .MAX_MARKERS (MAX_MARKERS),
      .ROW_BITS    (ROW_BITS)
   ) u_chain (
      .clock    (clock),
      .op       (chain_op),
      .push_row (req_row),
      .head_row (head_row)
   );

   assign req_row    = req_tdata[ROW_BITS-1:0];
   assign req_tready = (state_ff == rmhs_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign head_value = (count_ff == '0) ? '0 : head_row;

   assign limit_cmp      = CMP_W'(limit_ff);
   assign eff_limit      = (limit_cmp < MAX_CMP) ? limit_cmp : MAX_CMP;
   assign count_next_cmp = CMP_W'(count_ff) + CMP_W'(1);

   // During the walk the head cell holds entry step_ff of the history.
   assign in_history  = (CNT_W'(step_ff) < count_ff);
   assign at_or_below = (head_row <= bound_ff);

   always_comb begin
      state_in     = state_ff;
      limit_in     = csr_we ? csr_wdata : limit_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      bound_in     = bound_ff;
      prev_in      = prev_ff;
      hit_in       = hit_ff;
      res_jv_in    = res_jv_ff;
      res_row_in   = res_row_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_jv_in    = out_jv_ff;
      out_row_in   = out_row_ff;
      chain_op     = rmhs_pkg::OP_HOLD;

      unique case (state_ff)
         rmhs_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_tuser;
               step_in    = '0;
               hit_in     = 1'b0;
               res_jv_in  = 1'b0;
               res_row_in = '0;
               bound_in   = req_row;
               state_in   = rmhs_pkg::ST_DONE;
               case (req_tuser)
                  rmhs_pkg::CMD_MARK: begin
                     if (req_row != head_value) begin
                        chain_op = rmhs_pkg::OP_PUSH;
                        // A full history keeps its count whatever the limit.
                        if (count_ff != MAX_CNT && !(count_next_cmp > eff_limit)) begin
                           count_in = count_next_cmp[CNT_W-1:0];
                        end
                     end
                  end
                  rmhs_pkg::CMD_UP: begin
                     bound_in = (req_row == '0) ? '0 : req_row - ROW_BITS'(1);
                     state_in = rmhs_pkg::ST_WALK;
                  end
                  rmhs_pkg::CMD_DOWN: begin
                     state_in = rmhs_pkg::ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         rmhs_pkg::ST_WALK: begin
            chain_op = rmhs_pkg::OP_ROTATE;
            prev_in  = head_row;
            step_in  = step_ff + IDX_W'(1);
            if (!hit_ff && in_history && at_or_below) begin
               hit_in = 1'b1;
               if (cmd_ff == rmhs_pkg::CMD_UP) begin
                  res_jv_in  = 1'b1;
                  res_row_in = head_row;
               end else if (step_ff != '0) begin
                  // A down search answers with the next newer marker.
                  res_jv_in  = 1'b1;
                  res_row_in = prev_ff;
               end
            end
            if (step_ff == LAST_IDX) begin
               state_in = rmhs_pkg::ST_DONE;
            end
         end
         rmhs_pkg::ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_jv_in    = res_jv_ff;
               out_row_in   = res_row_ff;
               state_in     = rmhs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmhs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmhs_pkg::ST_IDLE;
         limit_ff     <= rmhs_pkg::LIMIT_RESET;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      cmd_ff     <= cmd_in;
      bound_ff   <= bound_in;
      prev_ff    <= prev_in;
      hit_ff     <= hit_in;
      res_jv_ff  <= res_jv_in;
      res_row_ff <= res_row_in;
      out_jv_ff  <= out_jv_in;
      out_row_ff <= out_row_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_jv_ff;
   assign rsp_tdata  = DATA_W'(out_row_ff);

   `RMHS_ASSERT(a_count_bounded, clock, reset, count_ff <= MAX_CNT,
                "marker count above capacity")
   `RMHS_ASSERT(a_walk_ends, clock, reset,
                (state_ff == rmhs_pkg::ST_WALK && step_ff == LAST_IDX)
                |=> (state_ff == rmhs_pkg::ST_DONE),
                "search walk did not end after one rotation")
   `RMHS_ASSERT(a_mark_no_walk, clock, reset,
                (accept && req_tuser == rmhs_pkg::CMD_MARK)
                |=> (state_ff == rmhs_pkg::ST_DONE && !res_jv_ff),
                "mark item started a walk or found a jump")
   `RMHS_ASSERT(a_jump_from_search, clock, reset,
                (state_ff == rmhs_pkg::ST_DONE && res_jv_ff)
                |-> (cmd_ff == rmhs_pkg::CMD_UP || cmd_ff == rmhs_pkg::CMD_DOWN),
                "jump found for a non-search item")
   `RMHS_ASSERT(a_count_step, clock, reset,
                !$past(reset) |-> (CMP_W'(count_ff) <= CMP_W'($past(count_ff)) + CMP_W'(1)),
                "marker count grew by more than one")

endmodule
